[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_RST(lbl, prop, msg)
`endif
`endif

[src/prawf_pkg.sv]
// ----------------------------------------------------------------------------
// prawf_pkg
// constants and types of the page run allocator
// ----------------------------------------------------------------------------
package prawf_pkg;
  localparam int NUM_PAGES = 1024;
  localparam int ADDR_W = 10;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] HEAP_RESET = CNT_W'(1024);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_EV, S_SCAN_END, S_PLACE,
    S_FILL, S_FREE_RD, S_FREE_EV, S_CLR_RUN, S_BRK_RD, S_BRK_EV, S_DONE
  } state_t;
endpackage

[src/page_run_allocator_exact_worst_fit_unit.sv]
// ----------------------------------------------------------------------------
// page_run_allocator_exact_worst_fit_unit
// page run allocator, exact fit then first largest fit, else break extension
// ----------------------------------------------------------------------------
// After reset the block clears all 1024 entries of its two page memories and
// accepts no beat until done. Each operation then runs through one read port
// per memory: an allocate walks the free runs below the break page by page,
// skipping each allocated run whole, then writes one page per cycle of the
// granted run; a free reads the run start, clears one page per cycle, and
// lowers the break one page at a time while the page below it is free.
// One operation is in flight at a time; a finished result may wait in the
// output register while the next beat is taken.
`include "assert_macros.svh"
module page_run_allocator_exact_worst_fit_unit
  import prawf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [CNT_W-1:0]  page_count,
  input  logic [ADDR_W-1:0] page_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [ADDR_W-1:0] start_page,
  output logic [CNT_W-1:0]  break_page
);

  state_t state, state_next;

  logic [CNT_W-1:0]  rl_mem [NUM_PAGES];
  logic              pu_mem [NUM_PAGES];
  logic [CNT_W-1:0]  rl_rdata;
  logic              pu_rdata;
  logic              rl_we, pu_we, pu_wdata;
  logic [ADDR_W-1:0] rl_waddr, rl_raddr, pu_waddr, pu_raddr;
  logic [CNT_W-1:0]  rl_wdata;

  logic [CNT_W-1:0]  heap_pages, brk, p, want, fill_cnt, fr_len, best_len;
  logic [ADDR_W-1:0] clr, base, fr_start, exact_at, best_at, res_start;
  logic              op_func, in_free, have_exact, res_status;

  logic [CNT_W-1:0]  top, avail, brk_m1;
  logic [CNT_W:0]    fill_addr;
  logic              fill_in, fill_last, close_exact, close_best;

  assign top = (heap_pages < CNT_W'(NUM_PAGES)) ? heap_pages : CNT_W'(NUM_PAGES);
  assign avail = (brk < top) ? top - brk : '0;
  assign brk_m1 = brk - CNT_W'(1);
  assign fill_addr = {2'b00, base} + {1'b0, fill_cnt};
  assign fill_in = fill_addr < (CNT_W+1)'(NUM_PAGES);
  assign fill_last = (fill_cnt == want - CNT_W'(1));
  assign close_exact = in_free && (fr_len == want) && !have_exact;
  assign close_best = in_free && (fr_len >= want) && (fr_len > best_len);
  assign in_ready = (state == S_IDLE);

  // memories
  always_ff @(posedge clk) begin
    if (rl_we) rl_mem[rl_waddr] <= rl_wdata;
    rl_rdata <= rl_mem[rl_raddr];
  end

  always_ff @(posedge clk) begin
    if (pu_we) pu_mem[pu_waddr] <= pu_wdata;
    pu_rdata <= pu_mem[pu_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (clr == ADDR_W'(NUM_PAGES - 1)) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (op_func == FUNC_FREE) state_next = S_FREE_RD;
        else if (want == '0 || want > avail) state_next = S_DONE;
        else state_next = S_SCAN_RD;
      end
      S_SCAN_RD:  state_next = (p < brk) ? S_SCAN_EV : S_SCAN_END;
      S_SCAN_EV:  state_next = S_SCAN_RD;
      S_SCAN_END: state_next = S_PLACE;
      S_PLACE:    state_next = S_FILL;
      S_FILL:     if (fill_last) state_next = S_DONE;
      S_FREE_RD:  state_next = S_FREE_EV;
      S_FREE_EV:  state_next = (rl_rdata == '0) ? S_DONE : S_CLR_RUN;
      S_CLR_RUN:  if (fill_last) state_next = S_BRK_RD;
      S_BRK_RD:   state_next = (brk == '0) ? S_DONE : S_BRK_EV;
      S_BRK_EV:   state_next = pu_rdata ? S_DONE : S_BRK_RD;
      S_DONE:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    rl_we = 1'b0;
    rl_waddr = base;
    rl_wdata = want;
    pu_we = 1'b0;
    pu_waddr = fill_addr[ADDR_W-1:0];
    pu_wdata = 1'b1;
    rl_raddr = (state == S_FREE_RD) ? base : p[ADDR_W-1:0];
    pu_raddr = brk_m1[ADDR_W-1:0];
    unique case (state)
      S_CLEAR: begin
        rl_we = 1'b1;
        rl_waddr = clr;
        rl_wdata = '0;
        pu_we = 1'b1;
        pu_waddr = clr;
        pu_wdata = 1'b0;
      end
      S_FILL: begin
        rl_we = (fill_cnt == '0);
        pu_we = fill_in;
      end
      S_FREE_EV: begin
        rl_we = (rl_rdata != '0);
        rl_wdata = '0;
      end
      S_CLR_RUN: begin
        pu_we = fill_in;
        pu_wdata = 1'b0;
      end
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      brk <= '0;
      heap_pages <= HEAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) heap_pages <= cfg_data;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: clr <= clr + ADDR_W'(1);
        S_IDLE: begin
          op_func <= func;
          want <= page_count;
          base <= page_index;
          p <= '0;
          in_free <= 1'b0;
          have_exact <= 1'b0;
          best_len <= '0;
          fill_cnt <= '0;
          res_status <= ST_REFUSED;
          res_start <= '0;
        end
        S_SCAN_EV: begin
          if (rl_rdata != '0) begin
            if (close_exact) begin
              have_exact <= 1'b1;
              exact_at <= fr_start;
            end
            if (close_best) begin
              best_len <= fr_len;
              best_at <= fr_start;
            end
            in_free <= 1'b0;
            p <= p + rl_rdata;
          end else begin
            if (!in_free) begin
              fr_start <= p[ADDR_W-1:0];
              fr_len <= CNT_W'(1);
            end else begin
              fr_len <= fr_len + CNT_W'(1);
            end
            in_free <= 1'b1;
            p <= p + CNT_W'(1);
          end
        end
        S_SCAN_END: begin
          if (close_exact) begin
            have_exact <= 1'b1;
            exact_at <= fr_start;
          end
          if (close_best) begin
            best_len <= fr_len;
            best_at <= fr_start;
          end
          in_free <= 1'b0;
        end
        S_PLACE: begin
          if (have_exact) begin
            base <= exact_at;
          end else if (best_len >= want && best_len != '0) begin
            base <= best_at;
          end else begin
            base <= brk[ADDR_W-1:0];
            brk <= brk + want;
          end
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + CNT_W'(1);
          res_status <= ST_OK;
          res_start <= base;
        end
        S_FREE_EV: want <= rl_rdata;
        S_CLR_RUN: begin
          fill_cnt <= fill_cnt + CNT_W'(1);
          res_status <= ST_OK;
        end
        S_BRK_RD: res_status <= ST_OK;
        S_BRK_EV: if (!pu_rdata) brk <= brk_m1;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= res_status;
            start_page <= res_start;
            break_page <= brk;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_brk_range, (brk <= CNT_W'(NUM_PAGES)), "break beyond page store")
  `ASSERT_CLK(a_fill_room, ((state == S_FILL) |-> fill_in), "run fill past page store")
  `ASSERT_CLK_RST(a_clear_after_rst, ($past(rst) |-> (state == S_CLEAR)), "no clear after reset")
  `ASSERT_CLK(a_no_overwrite, ((out_valid && !out_ready) |=> out_valid), "result dropped")

endmodule
